### rtl/edf_periodic_task_scheduler_defines.svh
// Assertion macros shared by the EDF scheduler RTL.
// Each macro expects signals clk and arst_n in the scope of use.
`ifndef EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EDFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define EDFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/edfs_pkg.sv
// Shared types and constants of the EDF scheduler: command codes, transaction payloads
// and the status flags of the per-slot evaluation unit. No dependencies.
`timescale 1ns / 1ps

package edfs_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_STAT = 2'd2;

	// request transaction
	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  task_slot;
		logic        slot_enable;
		logic [15:0] task_period;
		logic [15:0] task_exec;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [31:0] tick_time;
		logic        cpu_busy;
		logic [2:0]  running_slot;
		logic        job_done;
		logic [15:0] response_ticks;
		logic [7:0]  missed_mask;
		logic [15:0] stat_max_response;
		logic        stat_ever_missed;
	} rsp_t;

	// flags from the slot evaluation unit
	typedef struct packed {
		logic miss;     // unfinished job reached its deadline
		logic fire;     // new job released this tick
		logic pending;  // job left with work after miss/release
		logic better;   // earlier deadline than the current pick
	} eval_t;

endpackage

### rtl/edfs_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Used for the request and response channels of the EDF scheduler.
`timescale 1ns / 1ps

interface edfs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/edfs_slot_ram.sv
// Task slot record memory: one write port, one registered read port.
// Entries never written read back as all zero. No package dependencies.
`timescale 1ns / 1ps

module edfs_slot_ram #(
	parameter type rec_t  = logic [0:0],
	parameter int  DEPTH  = 8,
	parameter int  ADDR_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  rec_t              wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output rec_t              rd_data
);
	rec_t             mem [DEPTH];
	rec_t             rd_q;
	logic [DEPTH-1:0] loaded_q;
	logic             rd_loaded_q;

	// storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// written-entry flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			rd_loaded_q <= 1'b0;
		end else begin
			if (wr_en) begin
				loaded_q[wr_addr] <= 1'b1;
			end
			rd_loaded_q <= loaded_q[rd_addr];
		end
	end

	assign rd_data = rd_loaded_q ? rd_q : '0;
endmodule

### rtl/edfs_slot_alu.sv
// Shared per-slot evaluation unit: deadline miss, job release and deadline compare.
// Depends on edfs_pkg for the status flag struct.
`timescale 1ns / 1ps

module edfs_slot_alu #(
	parameter int TIME_BITS = 32
) (
	input  logic                 active,
	input  logic [TIME_BITS-1:0] time_now,
	input  logic [15:0]          period,
	input  logic [15:0]          exec_ticks,
	input  logic [15:0]          remaining,
	input  logic [TIME_BITS-1:0] next_rel,
	input  logic [TIME_BITS-1:0] deadline,
	input  logic                 best_vld,
	input  logic [TIME_BITS-1:0] best_deadline,
	output logic [15:0]          new_remaining,
	output logic [TIME_BITS-1:0] new_next_rel,
	output logic [TIME_BITS-1:0] new_deadline,
	output edfs_pkg::eval_t      flags
);
	logic [TIME_BITS-1:0] eff_period;
	logic [TIME_BITS-1:0] next_time;
	logic                 miss;
	logic                 fire;
	logic                 pending;

	// miss is checked ahead of the release
	assign miss = active && (remaining != '0) && (time_now >= deadline);
	assign fire = active && (time_now == next_rel);

	// zero period behaves as one; on release next_rel equals time_now
	assign eff_period = (period == '0) ? TIME_BITS'(1) : TIME_BITS'(period);
	assign next_time  = time_now + eff_period;

	assign new_remaining = fire ? exec_ticks : (miss ? 16'd0 : remaining);
	assign new_deadline  = fire ? next_time : deadline;
	assign new_next_rel  = fire ? next_time : next_rel;

	// strict less keeps the lowest slot on a tie
	assign pending = active && (new_remaining != '0);

	always_comb begin
		flags         = '0;
		flags.miss    = miss;
		flags.fire    = fire;
		flags.pending = pending;
		flags.better  = pending && (!best_vld || (new_deadline < best_deadline));
	end
endmodule

### rtl/edf_periodic_task_scheduler.sv
// EDF scheduler for periodic tasks, top level. Uses edfs_pkg, edfs_stream_if,
// edfs_slot_ram, edfs_slot_alu and the assertion macros header.
//
// Requests arrive on req (valid/ready): load a slot, advance one tick, or read slot
// statistics. Every request yields exactly one response transaction on rsp.
// A tick walks the task table one slot per cycle through the shared evaluation unit
// (miss check, release, earliest-deadline pick), then retires one tick of the chosen job.
// From accept to rsp.valid, a tick passes through the one-slot-per-cycle scan, the read stage
// (ST_DRAIN), the retire step (ST_FIN) and the response load (ST_DONE); a statistics read
// passes ST_STAT and ST_DONE, load and unknown commands ST_DONE only. req.ready is high only
// while idle, so a new request is taken only once the previous one has loaded its response.
// The response sits in an output register; a new request is taken while it waits,
// and a stalled rsp holds the next finished item in ST_DONE until the register is free.
// Reset clears time, slot enables and the written-slot flags at once, with no clearing
// pass; never loaded slots read as zero.
`timescale 1ns / 1ps
`include "edf_periodic_task_scheduler_defines.svh"

module edf_periodic_task_scheduler #(
	parameter int TASK_SLOTS = 8,
	parameter int TIME_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	edfs_stream_if.sink   req,
	edfs_stream_if.source rsp
);
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TASK_SLOTS - 1);

	typedef struct packed {
		logic [15:0]          period;
		logic [15:0]          exec_ticks;
		logic [15:0]          remaining;
		logic [TIME_BITS-1:0] next_rel;
		logic [TIME_BITS-1:0] deadline;
		logic [TIME_BITS-1:0] rel_time;
		logic [15:0]          max_resp;
		logic                 missed;
	} rec_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_FIN   = 6'b001000,
		ST_STAT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TASK_SLOTS-1:0] active_q;
	logic [SLOT_W-1:0]    rd_idx_q;
	logic                 ev_vld_s1;
	logic [SLOT_W-1:0]    ev_idx_s1;
	logic                 best_vld_q;
	logic [SLOT_W-1:0]    best_idx_q;
	rec_t                 best_q;
	logic [7:0]           miss_q;
	logic                 stat_ok_q;
	logic                 rsp_vld_q;
	edfs_pkg::rsp_t       res_q;
	edfs_pkg::rsp_t       rsp_q;

	logic                 req_acc;
	logic                 slot_ok;
	logic [SLOT_W-1:0]    req_slot;
	logic                 can_load;
	logic                 ev_active;
	logic                 take_best;
	logic [6:0]           ev_idx_ext;
	logic [SLOT_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	rec_t                 wr_data;
	rec_t                 rd_data;
	rec_t                 upd_rec;
	rec_t                 fin_rec;
	logic [15:0]          new_remaining;
	logic [TIME_BITS-1:0] new_next_rel;
	logic [TIME_BITS-1:0] new_deadline;
	edfs_pkg::eval_t      ev_flags;
	logic [15:0]          rem_dec;
	logic                 fin_done;
	logic [TIME_BITS-1:0] resp_full;
	logic [15:0]          resp_sat;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && (state_q == ST_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;
	assign can_load  = !rsp_vld_q || rsp.ready;

	// slot addressing of load and statistics read
	assign slot_ok  = (7'(req.data.task_slot) < 7'(TASK_SLOTS));
	assign req_slot = SLOT_W'(req.data.task_slot);

	// per-slot evaluation during the scan
	assign ev_active  = ev_vld_s1 && active_q[ev_idx_s1];
	assign ev_idx_ext = 7'(ev_idx_s1);

	edfs_slot_alu #(
		.TIME_BITS (TIME_BITS)
	) u_alu (
		.active        (ev_active),
		.time_now      (time_q),
		.period        (rd_data.period),
		.exec_ticks    (rd_data.exec_ticks),
		.remaining     (rd_data.remaining),
		.next_rel      (rd_data.next_rel),
		.deadline      (rd_data.deadline),
		.best_vld      (best_vld_q),
		.best_deadline (best_q.deadline),
		.new_remaining (new_remaining),
		.new_next_rel  (new_next_rel),
		.new_deadline  (new_deadline),
		.flags         (ev_flags)
	);

	assign take_best = ev_flags.better;

	always_comb begin
		upd_rec           = rd_data;
		upd_rec.remaining = new_remaining;
		upd_rec.next_rel  = new_next_rel;
		upd_rec.deadline  = new_deadline;
		upd_rec.rel_time  = ev_flags.fire ? time_q : rd_data.rel_time;
		upd_rec.missed    = rd_data.missed | ev_flags.miss;
	end

	// retire one tick of the chosen job
	assign rem_dec   = best_q.remaining - 16'd1;
	assign fin_done  = (rem_dec == '0);
	assign resp_full = time_q + TIME_BITS'(1) - best_q.rel_time;
	assign resp_sat  = (resp_full > TIME_BITS'(16'hFFFF)) ? 16'hFFFF : resp_full[15:0];

	always_comb begin
		fin_rec           = best_q;
		fin_rec.remaining = rem_dec;
		if (fin_done && (resp_sat > best_q.max_resp)) begin
			fin_rec.max_resp = resp_sat;
		end
	end

	// memory port selection
	assign rd_addr = (state_q == ST_SCAN) ? rd_idx_q : req_slot;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = req_slot;
		wr_data = upd_rec;
		if (req_acc && (req.data.cmd == edfs_pkg::CMD_LOAD) && slot_ok) begin
			wr_en              = 1'b1;
			wr_data            = '0;
			wr_data.period     = req.data.task_period;
			wr_data.exec_ticks = req.data.task_exec;
			wr_data.next_rel   = time_q;
			wr_data.deadline   = time_q;
			wr_data.rel_time   = time_q;
		end else if (ev_active) begin
			wr_en   = 1'b1;
			wr_addr = ev_idx_s1;
		end else if ((state_q == ST_FIN) && best_vld_q) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = fin_rec;
		end
	end

	edfs_slot_ram #(
		.rec_t  (rec_t),
		.DEPTH  (TASK_SLOTS),
		.ADDR_W (SLOT_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			time_q     <= '0;
			active_q   <= '0;
			rd_idx_q   <= '0;
			ev_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			stat_ok_q  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			ev_vld_s1 <= (state_q == ST_SCAN);
			// response valid: set when the result is loaded, cleared when taken
			if ((state_q == ST_DONE) && can_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (take_best) begin
				best_vld_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						stat_ok_q <= slot_ok;
						unique case (req.data.cmd)
							edfs_pkg::CMD_LOAD: begin
								if (slot_ok) begin
									active_q[req_slot] <= req.data.slot_enable;
								end
								state_q <= ST_DONE;
							end
							edfs_pkg::CMD_TICK: begin
								rd_idx_q   <= '0;
								best_vld_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
							edfs_pkg::CMD_STAT: state_q <= ST_STAT;
							default:            state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					time_q  <= time_q + TIME_BITS'(1);
					state_q <= ST_DONE;
				end
				ST_STAT: state_q <= ST_DONE;
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ev_idx_s1 <= rd_idx_q;
		if (req_acc) begin
			res_q  <= '0;
			miss_q <= '0;
		end
		if (take_best) begin
			best_q     <= upd_rec;
			best_idx_q <= ev_idx_s1;
		end
		if (ev_flags.miss && (ev_idx_ext < 7'd8)) begin
			miss_q[ev_idx_ext[2:0]] <= 1'b1;
		end
		if (state_q == ST_FIN) begin
			res_q.tick_time   <= 32'(time_q);
			res_q.missed_mask <= miss_q;
			if (best_vld_q) begin
				res_q.cpu_busy       <= 1'b1;
				res_q.running_slot   <= 3'(7'(best_idx_q));
				res_q.job_done       <= fin_done;
				res_q.response_ticks <= fin_done ? resp_sat : 16'd0;
			end
		end
		if (state_q == ST_STAT) begin
			res_q.stat_max_response <= stat_ok_q ? rd_data.max_resp : 16'd0;
			res_q.stat_ever_missed  <= stat_ok_q && rd_data.missed;
		end
		if ((state_q == ST_DONE) && can_load) begin
			rsp_q <= res_q;
		end
	end

	// checks
	`EDFS_ASSERT_NOW(a_best_pending, (state_q == ST_FIN) && best_vld_q, best_q.remaining != '0, "picked job has no work left")
	`EDFS_ASSERT_NOW(a_best_active, (state_q == ST_FIN) && best_vld_q, active_q[best_idx_q], "picked job belongs to an inactive slot")
	`EDFS_ASSERT_NEXT(a_time_step, state_q == ST_FIN, time_q == TIME_BITS'($past(time_q) + 1'b1), "time did not advance by one tick")
endmodule
